// ===== rtl/gzb_pkg.sv =====
// Shared types, constants and the power step schedule of the harmonic bin detector.
`timescale 1ns / 1ps

package gzb_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int DLY_W      = 40;
   localparam int BIN_W      = 3;
   localparam int POWER_W    = 48;
   localparam int NUM_REGS   = 6;
   localparam int REG_IDX_W  = 3;
   localparam int FRAC       = 14;
   localparam int DIG_W      = 16;
   localparam int MUL_A_W    = DIG_W + 1;
   localparam int MUL_B_W    = DLY_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int PVAL_W     = COEF_W + DLY_W;
   localparam int WIDE_W     = 64;
   localparam int ACC_W      = 104;
   localparam int SUM_W      = DLY_W + 6;
   localparam int PWR_STEPS  = 11;
   localparam int STEP_W     = 4;
   localparam int SHIFT_W    = 6;
   localparam int RSP_DATA_W = 56;

   localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_REGS] = '{
      16'sd32610, 16'sd32138, 16'sd31357, 16'sd30274, 16'sd28899, 16'sd27246
   };

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOADP,
      ACC_ADD,
      ACC_SUB
   } acc_mode_type;

   typedef struct packed {
      acc_mode_type         mode;
      logic [SHIFT_W-1:0]   shift;
   } acc_ctl_type;

   typedef enum logic [1:0] {
      SRC_COEF,
      SRC_Q1,
      SRC_Q2,
      SRC_P
   } opnd_src_type;

   typedef struct packed {
      opnd_src_type a_src;
      logic [1:0]   digit;
      logic         a_top;
      logic         b_is_q2;
      acc_ctl_type  ctl;
   } pwr_step_type;

   // Schedule of one bin's power: first P = coef * q1, then the two squares scaled
   // by 2^14 digit by digit, then P * q2 subtracted digit by digit.
   function automatic pwr_step_type pwr_step(input logic [STEP_W-1:0] step);
      pwr_step_type s;
      s = '0;
      unique case (step)
         4'd0: s = '{SRC_COEF, 2'd0, 1'b1, 1'b0, '{ACC_LOADP, 6'd0}};
         4'd1: s = '{SRC_Q1,   2'd0, 1'b0, 1'b0, '{ACC_ADD,   6'd14}};
         4'd2: s = '{SRC_Q1,   2'd1, 1'b0, 1'b0, '{ACC_ADD,   6'd30}};
         4'd3: s = '{SRC_Q1,   2'd2, 1'b1, 1'b0, '{ACC_ADD,   6'd46}};
         4'd4: s = '{SRC_Q2,   2'd0, 1'b0, 1'b1, '{ACC_ADD,   6'd14}};
         4'd5: s = '{SRC_Q2,   2'd1, 1'b0, 1'b1, '{ACC_ADD,   6'd30}};
         4'd6: s = '{SRC_Q2,   2'd2, 1'b1, 1'b1, '{ACC_ADD,   6'd46}};
         4'd7: s = '{SRC_P,    2'd0, 1'b0, 1'b1, '{ACC_SUB,   6'd0}};
         4'd8: s = '{SRC_P,    2'd1, 1'b0, 1'b1, '{ACC_SUB,   6'd16}};
         4'd9: s = '{SRC_P,    2'd2, 1'b0, 1'b1, '{ACC_SUB,   6'd32}};
         4'd10: s = '{SRC_P,   2'd3, 1'b1, 1'b1, '{ACC_SUB,   6'd48}};
         default: s = '{SRC_COEF, 2'd0, 1'b1, 1'b0, '{ACC_NONE, 6'd0}};
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/goertzel_harmonic_bins.sv =====
// A sample is taken in the idle state and then runs through the recurrence, where the
// shared multiplier serves one bin per cycle; no new sample is taken before the last
// bin's write back. The last sample of a block is followed by the power phase: eleven
// multiplies per bin through the same multiplier, one drain and one output load, which
// waits on an output stall. Reset clears the delay lines, sample count and output valid,
// and restores the six coefficient registers to their default harmonic values.
`timescale 1ns / 1ps

module goertzel_harmonic_bins
   import gzb_pkg::*;
#(
   parameter int BLOCK_LEN = 64,
   parameter int NUM_BINS  = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   // Sample input. tdata: sample [15:0].
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,
   // Bin power output. tdata: bin_index [2:0], power [50:3], zero pad [55:51].
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast,
   // Coefficient register writes, one Q2.14 value per bin.
   input  logic                   csr_we,
   input  logic [REG_IDX_W-1:0]   csr_index,
   input  logic [COEF_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(BLOCK_LEN);
   localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);
   localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PWR_STEPS - 1);
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC - 1);
   localparam logic signed [DLY_W-1:0] DLY_MAX = {1'b0, {(DLY_W-1){1'b1}}};
   localparam logic signed [DLY_W-1:0] DLY_MIN = {1'b1, {(DLY_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REC,
      ST_PWR_MUL,
      ST_PWR_DRAIN,
      ST_PWR_OUT
   } state_type;

   // Sequencer registers.
   state_type             state_ff, state_in;
   logic [BIN_W-1:0]      bin_ff, bin_in;
   logic [BIN_W-1:0]      wb_bin_ff, wb_bin_in;
   logic                  iss_done_ff, iss_done_in;
   logic                  pend_ff, pend_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [DLY_W-1:0] d1_hold_ff, d1_hold_in;
   logic signed [DLY_W-1:0] d2_hold_ff, d2_hold_in;
   acc_ctl_type           acc_ctl_ff, acc_ctl_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]      bin_index_ff, bin_index_in;
   logic [POWER_W-1:0]    power_ff, power_in;
   logic                  last_ff, last_in;

   // Coefficient registers and per-bin delay lines.
   logic signed [COEF_W-1:0] coef_ff [NUM_REGS];
   logic signed [DLY_W-1:0]  dly1_ff [NUM_BINS];
   logic signed [DLY_W-1:0]  dly2_ff [NUM_BINS];

   logic                     dly_we;
   logic [IDX_W-1:0]         dly_waddr;
   logic signed [DLY_W-1:0]  dly1_wdata;
   logic signed [DLY_W-1:0]  dly2_wdata;

   // Datapath signals.
   logic [IDX_W-1:0]         rd_idx;
   logic signed [COEF_W-1:0] coef_sel;
   logic signed [DLY_W-1:0]  q1;
   logic signed [DLY_W-1:0]  q2;
   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0] product;
   logic signed [PVAL_W-1:0] p_value;
   logic [POWER_W-1:0]       acc_power;
   pwr_step_type             cur_step;
   logic signed [WIDE_W-1:0] a_wide;
   logic [DIG_W-1:0]         a_digit;
   logic signed [PROD_W-1:0] rnd;
   logic signed [SUM_W-1:0]  q_sum;
   logic signed [DLY_W-1:0]  q0_sat;
   logic                     out_free;

   // The delay lines are read only at the bin the sequencer points at; the write
   // back of the recurrence uses copies taken in the issue cycle.
   assign rd_idx   = bin_ff[IDX_W-1:0];
   assign q1       = dly1_ff[rd_idx];
   assign q2       = dly2_ff[rd_idx];
   assign coef_sel = (bin_ff < BIN_W'(NUM_REGS)) ? coef_ff[bin_ff] : '0;
   assign cur_step = pwr_step(step_ff);

   // Operand selection for the shared multiplier. In the power phase the first operand
   // is the coefficient or one 16-bit digit of a wide value; the top digit is signed.
   always_comb begin
      unique case (cur_step.a_src)
         SRC_COEF: a_wide = WIDE_W'(coef_sel);
         SRC_Q1:   a_wide = WIDE_W'(q1);
         SRC_Q2:   a_wide = WIDE_W'(q2);
         SRC_P:    a_wide = WIDE_W'(p_value);
         default:  a_wide = '0;
      endcase
      a_digit = a_wide[DIG_W*cur_step.digit +: DIG_W];
      if (state_ff == ST_PWR_MUL) begin
         if (cur_step.a_src == SRC_COEF) begin
            op_a = MUL_A_W'(coef_sel);
         end else if (cur_step.a_top) begin
            op_a = {a_digit[DIG_W-1], a_digit};
         end else begin
            op_a = {1'b0, a_digit};
         end
         op_b = cur_step.b_is_q2 ? MUL_B_W'(q2) : MUL_B_W'(q1);
      end else begin
         op_a = MUL_A_W'(coef_sel);
         op_b = MUL_B_W'(q1);
      end
   end

   gzb_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   gzb_acc u_acc (
      .clock   (clock),
      .ctl     (acc_ctl_ff),
      .product (product),
      .p_value (p_value),
      .power   (acc_power)
   );

   // Recurrence write back: round coef * delay_one to an integer with halves going
   // up, subtract delay_two, add the sample and clamp to the 40-bit range.
   always_comb begin
      rnd   = product + RND_HALF;
      q_sum = SUM_W'($signed(rnd[PROD_W-1:FRAC])) - SUM_W'(d2_hold_ff) + SUM_W'(x_ff);
      if ((&q_sum[SUM_W-1:DLY_W-1]) || !(|q_sum[SUM_W-1:DLY_W-1])) begin
         q0_sat = q_sum[DLY_W-1:0];
      end else if (q_sum[SUM_W-1]) begin
         q0_sat = DLY_MIN;
      end else begin
         q0_sat = DLY_MAX;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer. A sample runs its bins through the multiplier one per cycle, each
   // bin written back in the cycle after its issue; the block's last sample is followed
   // by the power phase, one bin at a time, each result clearing that bin's delays.
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      wb_bin_in    = wb_bin_ff;
      iss_done_in  = iss_done_ff;
      pend_in      = 1'b0;
      step_in      = step_ff;
      count_in     = count_ff;
      x_in         = x_ff;
      d1_hold_in   = d1_hold_ff;
      d2_hold_in   = d2_hold_ff;
      acc_ctl_in   = '{ACC_NONE, '0};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      bin_index_in = bin_index_ff;
      power_in     = power_ff;
      last_in      = last_ff;
      dly_we       = 1'b0;
      dly_waddr    = wb_bin_ff[IDX_W-1:0];
      dly1_wdata   = q0_sat;
      dly2_wdata   = d1_hold_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in        = req_tdata;
               bin_in      = '0;
               iss_done_in = 1'b0;
               state_in    = ST_REC;
            end
         end
         ST_REC: begin
            if (!iss_done_ff) begin
               d1_hold_in = q1;
               d2_hold_in = q2;
               wb_bin_in  = bin_ff;
               pend_in    = 1'b1;
               if (bin_ff == BIN_LAST) begin
                  iss_done_in = 1'b1;
               end else begin
                  bin_in = bin_ff + 1'b1;
               end
            end
            if (pend_ff) begin
               dly_we = 1'b1;
               if (wb_bin_ff == BIN_LAST) begin
                  if (count_ff == CNT_LAST) begin
                     count_in = '0;
                     bin_in   = '0;
                     step_in  = '0;
                     state_in = ST_PWR_MUL;
                  end else begin
                     count_in = count_ff + 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_PWR_MUL: begin
            acc_ctl_in = cur_step.ctl;
            if (step_ff == STEP_LAST) begin
               state_in = ST_PWR_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PWR_DRAIN: begin
            state_in = ST_PWR_OUT;
         end
         ST_PWR_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               bin_index_in = bin_ff;
               power_in     = acc_power;
               last_in      = (bin_ff == BIN_LAST);
               dly_we       = 1'b1;
               dly_waddr    = rd_idx;
               dly1_wdata   = '0;
               dly2_wdata   = '0;
               if (bin_ff == BIN_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  bin_in   = bin_ff + 1'b1;
                  step_in  = '0;
                  state_in = ST_PWR_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bin_ff       <= '0;
         wb_bin_ff    <= '0;
         iss_done_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         step_ff      <= '0;
         count_ff     <= '0;
         acc_ctl_ff   <= '{ACC_NONE, '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bin_ff       <= bin_in;
         wb_bin_ff    <= wb_bin_in;
         iss_done_ff  <= iss_done_in;
         pend_ff      <= pend_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         acc_ctl_ff   <= acc_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      d1_hold_ff   <= d1_hold_in;
      d2_hold_ff   <= d2_hold_in;
      bin_index_ff <= bin_index_in;
      power_ff     <= power_in;
      last_ff      <= last_in;
   end

   // Delay lines start from zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            dly1_ff[i] <= '0;
            dly2_ff[i] <= '0;
         end
      end else if (dly_we) begin
         dly1_ff[dly_waddr] <= dly1_wdata;
         dly2_ff[dly_waddr] <= dly2_wdata;
      end
   end

   // Coefficient registers; writes to an index past the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= COEF_RESET[i];
         end
      end else if (csr_we && (csr_index < REG_IDX_W'(NUM_REGS))) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-POWER_W-BIN_W){1'b0}}, power_ff, bin_index_ff};
   assign rsp_tlast  = last_ff;

   // An accepted sample leaves the block busy, so two samples are never accepted back to back.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sample accepted on consecutive cycles");

   // The block marker sits only on the final bin.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[BIN_W-1:0] == BIN_LAST))
      else $error("last marker on a bin other than the final one");

   // The accumulator is driven only by steps issued in the power phase.
   assert property (@(posedge clock) disable iff (reset)
      (acc_ctl_ff.mode != ACC_NONE) |-> $past(state_ff == ST_PWR_MUL))
      else $error("accumulator step outside the power phase");

   // A new result appears only from the output load of the power phase.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_PWR_OUT))
      else $error("result transaction raised outside the output state");

endmodule

// ===== rtl/gzb_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module gzb_mul
   import gzb_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic signed [PROD_W-1:0]  product
);

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== rtl/gzb_acc.sv =====
// Wide accumulator for the bin power, with the held cross product and saturation.
`timescale 1ns / 1ps

module gzb_acc
   import gzb_pkg::*;
(
   input  logic                      clock,
   input  acc_ctl_type               ctl,
   input  logic signed [PROD_W-1:0]  product,
   output logic signed [PVAL_W-1:0]  p_value,
   output logic [POWER_W-1:0]        power
);

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [PVAL_W-1:0] p_ff;
   logic signed [PVAL_W-1:0] p_in;
   logic signed [ACC_W-1:0]  term;

   assign term = ACC_W'(product) <<< ctl.shift;

   always_comb begin
      acc_in = acc_ff;
      p_in   = p_ff;
      unique case (ctl.mode)
         ACC_NONE: acc_in = acc_ff;
         ACC_LOADP: begin
            acc_in = '0;
            p_in   = product[PVAL_W-1:0];
         end
         ACC_ADD: acc_in = acc_ff + term;
         ACC_SUB: acc_in = acc_ff - term;
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      p_ff   <= p_in;
   end

   // The sum holds the power scaled by 2^14; drop the fraction and clamp.
   always_comb begin
      if (acc_ff[ACC_W-1]) begin
         power = '0;
      end else if (|acc_ff[ACC_W-2:FRAC+POWER_W]) begin
         power = '1;
      end else begin
         power = acc_ff[FRAC+POWER_W-1:FRAC];
      end
   end

   assign p_value = p_ff;

endmodule

// ===== test/goertzel_harmonic_bins_tb.sv =====
// Self-checking testbench for the six-bin Goertzel harmonic power detector.
`timescale 1ns / 1ps

module goertzel_harmonic_bins_tb
   import gzb_pkg::*;
();

   // The block is tested in its shipped configuration: 64 samples per block, six bins.
   localparam int BLK_LEN = 64;
   localparam int NBINS = 6;
   localparam int RAND_BLOCKS = 3;
   localparam int IDLE_PCT = 37;
   // Twice the time of one sample and of the power phase at a block's end is a safe
   // settling time before a register write or the end.
   localparam int QUIET_CYCLES = 2 * (NBINS * 13 + NBINS + 2);
   // The limit lies well above the length of the slowest correct run.
   localparam int CYCLE_LIMIT = 500000;
   localparam longint DLY_MAX = 64'sd549755813887;
   localparam longint DLY_MIN = -DLY_MAX - 1;
   localparam logic [POWER_W-1:0] POWER_SAT = {POWER_W{1'b1}};

   // Kinds of rows in the directed table. A register row writes one coefficient; every
   // other row sends one whole block of 64 samples in the named pattern.
   typedef enum logic [2:0] {
      ROW_CSR,
      ROW_ZERO,
      ROW_TAIL,
      ROW_CONST,
      ROW_ALT,
      ROW_WALK
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [REG_IDX_W-1:0]  idx;
      logic [SAMPLE_W-1:0]   val;
      logic                  has_power;
      logic [POWER_W-1:0]    power;
   } stim_row_type;

   typedef enum logic [1:0] {
      STYLE_FULL,
      STYLE_QUIET,
      STYLE_RAIL,
      STYLE_SPARSE
   } sample_style_type;

   typedef struct packed {
      logic [BIN_W-1:0]   bin;
      logic [POWER_W-1:0] power;
      logic               last;
   } bin_power_type;

   // Directed stimulus. An all-zero block gives zero power in every bin, and a block
   // that is zero but for its final sample x leaves q1 = x and q2 = 0, so each bin's
   // power is exactly x squared whatever its coefficient. Those rows carry the power
   // typed in; the others are checked against the predictor. The register rows write
   // every coefficient, the first two to the extremes, and also write the two indexes
   // past the last register, which the block must ignore.
   localparam int DIR_ROWS = 11;
   localparam stim_row_type DIR_TAB [DIR_ROWS] = '{
      '{ROW_ZERO,  3'd0, 16'h0000, 1'b1, 48'd0},
      '{ROW_TAIL,  3'd0, 16'h8000, 1'b1, 48'd1073741824},
      '{ROW_CSR,   3'd0, 16'h8000, 1'b0, 48'd0},
      '{ROW_CSR,   3'd1, 16'h7fff, 1'b0, 48'd0},
      '{ROW_CSR,   3'd2, 16'h0000, 1'b0, 48'd0},
      '{ROW_CSR,   3'd3, 16'h4000, 1'b0, 48'd0},
      '{ROW_CSR,   3'd4, 16'hc000, 1'b0, 48'd0},
      '{ROW_CSR,   3'd5, 16'hffff, 1'b0, 48'd0},
      '{ROW_CSR,   3'd6, 16'h3039, 1'b0, 48'd0},
      '{ROW_CSR,   3'd7, 16'hcfc7, 1'b0, 48'd0},
      '{ROW_CONST, 3'd0, 16'h8000, 1'b0, 48'd0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [REG_IDX_W-1:0]   csr_index = '0;
   logic [COEF_W-1:0]      csr_wdata = '0;

   // Predictor state: coefficients, both delay lines and the position in the block.
   longint bin_coef [NUM_REGS];
   longint dly_one [NBINS];
   longint dly_two [NBINS];
   int     samples_in_block;

   // Bin powers predicted but not yet seen on the result channel, oldest first.
   bin_power_type pending_powers [$];

   int  error_count = 0;
   int  cycle_count = 0;
   bit  sender_idles = 1'b1;
   bit  sink_idles = 1'b1;

   goertzel_harmonic_bins #(
      .BLOCK_LEN (BLK_LEN),
      .NUM_BINS  (NBINS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),       // sample [15:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),       // bin_index [2:0], power [50:3], zero pad [55:51]
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Squared magnitude of one bin, worked out exactly at 128 bits in Q.14 and then
   // floored to an integer. A negative sum gives zero and an overflow saturates.
   function automatic logic [POWER_W-1:0] bin_power_of(input longint c, input longint q1,
                                                       input longint q2);
      logic signed [127:0] w1;
      logic signed [127:0] w2;
      logic signed [127:0] wc;
      logic signed [127:0] sum;
      w1 = q1;
      w2 = q2;
      wc = c;
      sum = ((w1 * w1 + w2 * w2) <<< FRAC) - wc * w1 * w2;
      if (sum < 0) begin
         return '0;
      end
      sum = sum >>> FRAC;
      if (sum > 128'sd281474976710655) begin
         return POWER_SAT;
      end
      return sum[POWER_W-1:0];
   endfunction

   // Advances every bin's recurrence by one sample. On the last sample of a block the
   // six bin powers are queued in bin order and the delay lines start over from zero.
   task automatic goertzel_step(input logic [SAMPLE_W-1:0] x);
      longint        xs;
      longint        prod;
      longint        q0;
      bin_power_type res;
      xs = longint'($signed(x));
      for (int b = 0; b < NBINS; b++) begin
         // Rounding adds one half and shifts with floor, so halves round up.
         prod = bin_coef[b] * dly_one[b] + 64'sd8192;
         q0 = (prod >>> FRAC) - dly_two[b] + xs;
         if (q0 > DLY_MAX) begin
            q0 = DLY_MAX;
         end else if (q0 < DLY_MIN) begin
            q0 = DLY_MIN;
         end
         dly_two[b] = dly_one[b];
         dly_one[b] = q0;
      end
      samples_in_block++;
      if (samples_in_block == BLK_LEN) begin
         for (int b = 0; b < NBINS; b++) begin
            res.bin = BIN_W'(b);
            res.power = bin_power_of(bin_coef[b], dly_one[b], dly_two[b]);
            res.last = (b == NBINS - 1);
            pending_powers.push_back(res);
            dly_one[b] = 0;
            dly_two[b] = 0;
         end
         samples_in_block = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   // Offers one sample from a falling edge, with random idle cycles in front of it,
   // and returns at the rising edge where the transaction completes.
   task automatic send_sample(input logic [SAMPLE_W-1:0] x);
      @(negedge clock);
      while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = x;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      goertzel_step(x);
   endtask

   // Holds off the sender until every queued power has come out, then lets the block
   // settle, since a sample in the middle of a block yields no transaction to wait on.
   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_powers.size() != 0) begin
         @(negedge clock);
      end
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // Called at a falling edge while the block is idle. Indexes past the last register
   // leave the predictor untouched, just as the block must.
   task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx < NUM_REGS) begin
         bin_coef[idx] = longint'($signed(val));
      end
   endtask

   function automatic logic [SAMPLE_W-1:0] pattern_sample(input row_kind_type kind,
                                                          input logic [SAMPLE_W-1:0] val,
                                                          input int n);
      case (kind)
         ROW_TAIL:  return (n == BLK_LEN - 1) ? val : '0;
         ROW_CONST: return val;
         ROW_ALT:   return n[0] ? ~val : val;
         // A one walking through every bit, then its complement, so each bit of the
         // sample takes both values.
         ROW_WALK:  return (n % 32 < 16) ? (16'h0001 << (n % 16)) : ~(16'h0001 << (n % 16));
         default:   return '0;
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample(input sample_style_type style);
      case (style)
         STYLE_QUIET:  return SAMPLE_W'(int'($urandom_range(400)) - 200);
         STYLE_RAIL:   return $urandom_range(1) ? 16'h7fff : 16'h8000;
         STYLE_SPARSE: return ($urandom_range(7) == 0) ? SAMPLE_W'($urandom) : '0;
         default:      return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Half the coefficients are in the range a real harmonic bin would use, with the
   // extremes, zero and arbitrary values making up the rest.
   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(2))
               0:       return 16'h8000;
               1:       return 16'h7fff;
               default: return 16'h0000;
            endcase
         end
         1:       return COEF_W'($urandom);
         default: return COEF_W'($urandom_range(32767, 16000));
      endcase
   endfunction

   // The result side stalls at random while sink_idles is set, changed at falling edges.
   always @(negedge clock) begin
      rsp_tready = sink_idles ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
   end

   // Every completed result transaction is held against the oldest queued power.
   always @(posedge clock) begin : check_results
      bin_power_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_powers.size() == 0) begin
            report_mismatch("unexpected result, bin", 64'(rsp_tdata[2:0]), 64'd0);
         end else begin
            want = pending_powers.pop_front();
            if (rsp_tdata[2:0] !== want.bin) begin
               report_mismatch("bin_index", 64'(rsp_tdata[2:0]), 64'(want.bin));
            end
            if (rsp_tdata[50:3] !== want.power) begin
               report_mismatch("power", 64'(rsp_tdata[50:3]), 64'(want.power));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
            end
         end
      end
   end

   // Guards against a hang: a missing result or a stuck handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type     row;
      bin_power_type    fix;
      sample_style_type style;

      for (int i = 0; i < NUM_REGS; i++) begin
         bin_coef[i] = longint'(COEF_RESET[i]);
      end
      for (int b = 0; b < NBINS; b++) begin
         dly_one[b] = 0;
         dly_two[b] = 0;
      end
      samples_in_block = 0;

      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Directed part: walk the table. Rows with a typed power overwrite the predicted
      // power of the block's six results right after its last sample is taken.
      for (int r = 0; r < DIR_ROWS; r++) begin
         row = DIR_TAB[r];
         if (row.kind == ROW_CSR) begin
            wait_quiet();
            write_coef(row.idx, row.val);
         end else begin
            for (int n = 0; n < BLK_LEN; n++) begin
               send_sample(pattern_sample(row.kind, row.val, n));
            end
            if (row.has_power) begin
               for (int k = pending_powers.size() - NBINS; k < pending_powers.size(); k++) begin
                  fix = pending_powers[k];
                  fix.power = row.power;
                  pending_powers[k] = fix;
               end
            end
         end
      end

      // Random part: whole blocks of random samples in one of several styles. Before the
      // first block, and at random before the others, the sender waits for every result and
      // rewrites some coefficients, out-of-range indexes included. The second block runs with
      // no idling on either side, and the third changes a coefficient halfway through a block.
      for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
         sender_idles = (blk != 1);
         sink_idles = (blk != 1);
         if (blk == 0 || $urandom_range(1) == 1) begin
            wait_quiet();
            repeat ($urandom_range(6, 1)) write_coef(REG_IDX_W'($urandom_range(7)), pick_coef());
         end
         style = sample_style_type'($urandom_range(3));
         if (blk == 0) begin
            style = STYLE_FULL;
         end
         for (int n = 0; n < BLK_LEN; n++) begin
            if (blk == 2 && n == BLK_LEN / 2) begin
               wait_quiet();
               write_coef(REG_IDX_W'($urandom_range(NUM_REGS - 1)), pick_coef());
            end
            send_sample(random_sample(style));
         end
      end

      sender_idles = 1'b1;
      sink_idles = 1'b1;
      wait_quiet();

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
